[design/sssp_pkg.sv]
// ----------------------------------------------------------------------------
// sssp_pkg: shared constants, types and helpers for the shortest path block
// Sizes of the vertex set, the edge weights and the distances, the packing of
// the stream payloads and the control bundle that goes to the search engine.
// ----------------------------------------------------------------------------
package sssp_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int WEIGHT_BITS  = 16;
   localparam int DIST_BITS    = 24;

   localparam int VIDX_BITS  = $clog2(MAX_VERTICES);
   localparam int VCNT_BITS  = $clog2(MAX_VERTICES + 1);
   localparam int CADDR_BITS = 2 * VIDX_BITS;
   localparam int SUM_BITS   = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

   localparam logic [WEIGHT_BITS-1:0] W_NONE = '1;
   localparam logic [DIST_BITS-1:0]   D_NONE = '1;
   localparam logic [DIST_BITS-1:0]   D_SAT  = D_NONE - DIST_BITS'(1);

   // stream payload packing
   localparam int REQ_FIELD_BITS = 2 * VIDX_BITS + WEIGHT_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = VIDX_BITS + DIST_BITS + 1;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // item kinds
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   // register indexes
   localparam int   CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNT  = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [VIDX_BITS-1:0] src;
      logic [VCNT_BITS-1:0] count;
      logic                 rd_en;
      logic [VIDX_BITS-1:0] rd_idx;
   } eng_ctl_type;

   function automatic logic [DIST_BITS-1:0] sat_dist(input logic [SUM_BITS-1:0] value);
      logic [DIST_BITS-1:0] result;
      if (value > SUM_BITS'(D_SAT)) begin
         result = D_SAT;
      end else begin
         result = value[DIST_BITS-1:0];
      end
      return result;
   endfunction

endpackage

[design/single_source_shortest_path.sv]
// ----------------------------------------------------------------------------
// single_source_shortest_path: dense matrix shortest path search
// Input stream: req_tuser selects the item kind. A load item writes one edge
// weight of the cost matrix and gives no result. A run item with no readout
// pending latches source and vertex count (n), runs the search and returns
// the distance of vertex 0. Each further run item returns the next vertex
// until the one marked with rsp_tlast; the run item after that starts a new
// search.
// A search loads the initial row, then runs up to n-1 rounds (minimum
// scan, pick, relax), each walking the distance memory one entry per
// cycle; after it the result of vertex 0 passes the memory read and the
// output register.
// A readout item goes through three steps: accept, memory read, output register.
// req_tready is high whenever no item is in work; a load is taken while a
// result waits in the output register, a run item waits there until the
// receiver takes the earlier result. Stalls of rsp_tready hold the result.
// Reset clears the registers (source 0, count 16), the readout and the
// settled flags; the cost matrix is undefined until loaded.
// ----------------------------------------------------------------------------
module single_source_shortest_path (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // from_vertex, to_vertex, weight
   input  logic [sssp_pkg::REQ_TDATA_BITS-1:0]     req_tdata,
   // op
   input  logic                                    req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // vertex, distance, reachable, zero fill
   output logic [sssp_pkg::RSP_TDATA_BITS-1:0]     rsp_tdata,
   output logic                                    rsp_tlast,
   input  logic                                    csr_we,
   input  logic [sssp_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sssp_pkg::VCNT_BITS-1:0]          csr_wdata
);

   localparam logic [1:0] T_IDLE   = 2'd0;
   localparam logic [1:0] T_SEARCH = 2'd1;
   localparam logic [1:0] T_READ   = 2'd2;
   localparam logic [1:0] T_EMIT   = 2'd3;

   localparam int VI = sssp_pkg::VIDX_BITS;
   localparam int VC = sssp_pkg::VCNT_BITS;
   localparam int WB = sssp_pkg::WEIGHT_BITS;
   localparam int DB = sssp_pkg::DIST_BITS;

   logic [1:0]    state_ff, state_in;
   logic [VI-1:0] src_ff;
   logic [VC-1:0] count_ff;
   logic          rd_active_ff, rd_active_in;
   logic [VI-1:0] rd_next_ff, rd_next_in;
   logic [VC-1:0] rd_count_ff, rd_count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [sssp_pkg::RSP_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          op;
   logic [VI-1:0] from_vertex;
   logic [VI-1:0] to_vertex;
   logic [WB-1:0] weight;
   logic [VC-1:0] run_count;
   logic          fin;
   logic          reachable;

   sssp_pkg::eng_ctl_type eng_ctl;
   logic                  eng_busy;
   logic [DB-1:0]         eng_rd_data;

   assign req_tready  = state_ff == T_IDLE;
   assign accept      = req_tvalid && req_tready;
   assign op          = req_tuser;
   assign from_vertex = req_tdata[VI-1:0];
   assign to_vertex   = req_tdata[2*VI-1:VI];
   assign weight      = req_tdata[2*VI+WB-1:2*VI];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // count out of range: zero acts as one, too large acts as the maximum
   always_comb begin
      if (count_ff == '0) begin
         run_count = VC'(1);
      end else if (count_ff > VC'(sssp_pkg::MAX_VERTICES)) begin
         run_count = VC'(sssp_pkg::MAX_VERTICES);
      end else begin
         run_count = count_ff;
      end
   end

   assign fin       = (VC'(rd_next_ff) + VC'(1)) >= rd_count_ff;
   assign reachable = eng_rd_data != sssp_pkg::D_NONE;

   always_comb begin
      state_in       = state_ff;
      rd_active_in   = rd_active_ff;
      rd_next_in     = rd_next_ff;
      rd_count_in    = rd_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      eng_ctl.start  = 1'b0;
      eng_ctl.src    = src_ff;
      eng_ctl.count  = run_count;
      eng_ctl.rd_en  = 1'b0;
      eng_ctl.rd_idx = rd_next_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept && op == sssp_pkg::OP_RUN) begin
               if (rd_active_ff) begin
                  state_in = T_READ;
               end else begin
                  eng_ctl.start = 1'b1;
                  rd_active_in  = 1'b1;
                  rd_next_in    = '0;
                  rd_count_in   = run_count;
                  state_in      = T_SEARCH;
               end
            end
         end
         T_SEARCH: begin
            if (!eng_busy) begin
               state_in = T_READ;
            end
         end
         T_READ: begin
            eng_ctl.rd_en = 1'b1;
            state_in      = T_EMIT;
         end
         T_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sssp_pkg::RSP_TDATA_BITS'({reachable, eng_rd_data, rd_next_ff});
               rsp_last_in  = fin;
               if (fin) begin
                  rd_active_in = 1'b0;
                  rd_next_in   = '0;
               end else begin
                  rd_next_in = rd_next_ff + VI'(1);
               end
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rd_active_ff <= 1'b0;
         rd_next_ff   <= '0;
         rd_count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_active_ff <= rd_active_in;
         rd_next_ff   <= rd_next_in;
         rd_count_ff  <= rd_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff   <= '0;
         count_ff <= VC'(sssp_pkg::MAX_VERTICES);
      end else if (csr_we) begin
         unique case (csr_index)
            sssp_pkg::CSR_SOURCE: src_ff   <= csr_wdata[VI-1:0];
            sssp_pkg::CSR_COUNT:  count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   sssp_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .ctl        (eng_ctl),
      .load_we    (accept && op == sssp_pkg::OP_LOAD),
      .load_addr  ({from_vertex, to_vertex}),
      .load_wdata (weight),
      .busy       (eng_busy),
      .rd_data    (eng_rd_data)
   );

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      eng_ctl.start |-> !eng_busy && !rd_active_ff)
      else $error("search started while busy or reading out");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_EMIT |-> VC'(rd_next_ff) < rd_count_ff)
      else $error("readout index beyond the vertex count");

   a_last_ends_readout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in && !rsp_valid_ff && rsp_last_in |=> !rd_active_ff)
      else $error("readout still pending after the last result");

endmodule

[design/sssp_engine.sv]
// ----------------------------------------------------------------------------
// sssp_engine: memory based search sequencer
// Holds the cost matrix and the distance table in synchronous memories and
// walks them one entry a cycle: initial row load, minimum scan, edge relax.
// ----------------------------------------------------------------------------
module sssp_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sssp_pkg::eng_ctl_type                ctl,
   input  logic                                 load_we,
   input  logic [sssp_pkg::CADDR_BITS-1:0]      load_addr,
   input  logic [sssp_pkg::WEIGHT_BITS-1:0]     load_wdata,
   output logic                                 busy,
   output logic [sssp_pkg::DIST_BITS-1:0]       rd_data
);

   localparam logic [2:0] E_IDLE  = 3'd0;
   localparam logic [2:0] E_INIT  = 3'd1;
   localparam logic [2:0] E_SCAN  = 3'd2;
   localparam logic [2:0] E_PICK  = 3'd3;
   localparam logic [2:0] E_RELAX = 3'd4;

   localparam int VI = sssp_pkg::VIDX_BITS;
   localparam int VC = sssp_pkg::VCNT_BITS;
   localparam int DB = sssp_pkg::DIST_BITS;
   localparam int WB = sssp_pkg::WEIGHT_BITS;
   localparam int SB = sssp_pkg::SUM_BITS;
   localparam int NV = sssp_pkg::MAX_VERTICES;

   logic [WB-1:0] cost_mem [NV*NV];
   logic [DB-1:0] dist_mem [NV];

   logic [2:0]    state_ff, state_in;
   logic [VC-1:0] cnt_ff, cnt_in;
   logic [VC-1:0] round_ff, round_in;
   logic [VI-1:0] src_ff, src_in;
   logic [VC-1:0] n_ff, n_in;
   logic [VI-1:0] u_ff, u_in;
   logic [DB-1:0] du_ff, du_in;
   logic [DB-1:0] low_ff, low_in;
   logic          found_ff, found_in;
   logic [NV-1:0] settled_ff, settled_in;

   logic [WB-1:0] cost_rdata_ff;
   logic [DB-1:0] dist_rdata_ff;

   logic                           cost_re;
   logic [sssp_pkg::CADDR_BITS-1:0] cost_raddr;
   logic          dist_re;
   logic [VI-1:0] dist_raddr;
   logic          dist_we;
   logic [VI-1:0] dist_waddr;
   logic [DB-1:0] dist_wdata;

   logic          issue;
   logic          proc;
   logic [VC-1:0] prev_cnt;
   logic [VI-1:0] p_idx;
   logic [VI-1:0] c_idx;
   logic [DB-1:0] relax_sum;
   logic [VC-1:0] round_next;

   assign issue      = cnt_ff < n_ff;
   assign proc       = cnt_ff != '0;
   assign prev_cnt   = cnt_ff - VC'(1);
   assign p_idx      = prev_cnt[VI-1:0];
   assign c_idx      = cnt_ff[VI-1:0];
   assign relax_sum  = sssp_pkg::sat_dist(SB'(du_ff) + SB'(cost_rdata_ff));
   assign round_next = round_ff + VC'(1);
   assign busy       = state_ff != E_IDLE;
   assign rd_data    = dist_rdata_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      round_in   = round_ff;
      src_in     = src_ff;
      n_in       = n_ff;
      u_in       = u_ff;
      du_in      = du_ff;
      low_in     = low_ff;
      found_in   = found_ff;
      settled_in = settled_ff;
      cost_re    = 1'b0;
      cost_raddr = {src_ff, c_idx};
      dist_re    = 1'b0;
      dist_raddr = c_idx;
      dist_we    = 1'b0;
      dist_waddr = p_idx;
      dist_wdata = sssp_pkg::D_NONE;
      unique case (state_ff)
         E_IDLE: begin
            dist_re    = ctl.rd_en;
            dist_raddr = ctl.rd_idx;
            if (ctl.start) begin
               state_in   = E_INIT;
               cnt_in     = '0;
               round_in   = VC'(1);
               src_in     = ctl.src;
               n_in       = ctl.count;
               settled_in = '0;
               if (VC'(ctl.src) < ctl.count) begin
                  settled_in[ctl.src] = 1'b1;
               end
            end
         end
         E_INIT: begin
            // distances start as the source row
            cost_re    = issue;
            cost_raddr = {src_ff, c_idx};
            if (proc) begin
               dist_we = 1'b1;
               if (p_idx == src_ff) begin
                  dist_wdata = '0;
               end else if (cost_rdata_ff == sssp_pkg::W_NONE) begin
                  dist_wdata = sssp_pkg::D_NONE;
               end else begin
                  dist_wdata = sssp_pkg::sat_dist(SB'(cost_rdata_ff));
               end
            end
            cnt_in = cnt_ff + VC'(1);
            if (cnt_ff == n_ff) begin
               cnt_in   = '0;
               low_in   = sssp_pkg::D_NONE;
               found_in = 1'b0;
               state_in = (round_ff < n_ff) ? E_SCAN : E_IDLE;
            end
         end
         E_SCAN: begin
            // strict compare keeps the lowest index on ties
            dist_re    = issue;
            dist_raddr = c_idx;
            if (proc && !settled_ff[p_idx] && dist_rdata_ff < low_ff) begin
               low_in   = dist_rdata_ff;
               u_in     = p_idx;
               found_in = 1'b1;
            end
            cnt_in = cnt_ff + VC'(1);
            if (cnt_ff == n_ff) begin
               state_in = E_PICK;
            end
         end
         E_PICK: begin
            cnt_in = '0;
            if (found_ff) begin
               settled_in[u_ff] = 1'b1;
               du_in            = low_ff;
               state_in         = E_RELAX;
            end else begin
               state_in = E_IDLE;
            end
         end
         E_RELAX: begin
            cost_re    = issue;
            cost_raddr = {u_ff, c_idx};
            dist_re    = issue;
            dist_raddr = c_idx;
            if (proc && !settled_ff[p_idx] && cost_rdata_ff != sssp_pkg::W_NONE &&
                dist_rdata_ff > relax_sum) begin
               dist_we    = 1'b1;
               dist_wdata = relax_sum;
            end
            cnt_in = cnt_ff + VC'(1);
            if (cnt_ff == n_ff) begin
               cnt_in   = '0;
               round_in = round_next;
               low_in   = sssp_pkg::D_NONE;
               found_in = 1'b0;
               state_in = (round_next < n_ff) ? E_SCAN : E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= E_IDLE;
         cnt_ff     <= '0;
         round_ff   <= '0;
         found_ff   <= 1'b0;
         settled_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         round_ff   <= round_in;
         found_ff   <= found_in;
         settled_ff <= settled_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      n_ff   <= n_in;
      u_ff   <= u_in;
      du_ff  <= du_in;
      low_ff <= low_in;
   end

   // cost matrix: written by load transfers, read by the sequencer
   always_ff @(posedge clock) begin
      if (load_we) begin
         cost_mem[load_addr] <= load_wdata;
      end
      if (cost_re) begin
         cost_rdata_ff <= cost_mem[cost_raddr];
      end
   end

   // distance table: each phase drains before the next one reads
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      if (dist_re) begin
         dist_rdata_ff <= dist_mem[dist_raddr];
      end
   end

   a_relax_from_settled: assert property (@(posedge clock) disable iff (reset)
      state_ff == E_RELAX |-> settled_ff[u_ff])
      else $error("relax from a vertex that is not settled");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      dist_we && dist_re |-> dist_waddr != dist_raddr)
      else $error("distance read and write hit the same entry");

   a_readout_when_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |-> state_ff == E_IDLE && !ctl.start)
      else $error("distance readout during a search");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == E_SCAN |-> round_ff < n_ff)
      else $error("scan beyond the last round");

   a_no_load_in_search: assert property (@(posedge clock) disable iff (reset)
      load_we |-> state_ff == E_IDLE)
      else $error("cost load while the search runs");

endmodule

[sim/single_source_shortest_path_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_source_shortest_path_test: stream-level test of the shortest path block
// Fills the whole cost matrix, runs a few hand-picked searches, then random
// phases of edge loads and distance readouts under changing source and vertex
// count settings. Every returned distance is compared with a local
// Dijkstra search kept in a scoreboard.
// ----------------------------------------------------------------------------
module single_source_shortest_path_test;
   import sssp_pkg::*;

   localparam int QUIET_LIMIT  = 8000;
   localparam int TARGET_ITEMS = 800;
   localparam int HOLD_CYCLES  = 1500;

   typedef struct packed {
      logic [VIDX_BITS-1:0] vertex;
      logic [DIST_BITS-1:0] distance;
      logic                 reachable;
      logic                 last;
   } vertex_distance_type;

   class distance_tracker_type;
      logic [WEIGHT_BITS-1:0] edge_cost [MAX_VERTICES][MAX_VERTICES];
      logic [DIST_BITS-1:0]   path_dist [MAX_VERTICES];
      bit                     settled [MAX_VERTICES];
      logic [VIDX_BITS-1:0]   source_reg;
      logic [VCNT_BITS-1:0]   count_reg;
      bit                     readout_busy;
      int unsigned            next_vertex;
      int unsigned            readout_len;
      vertex_distance_type    expected_distances [$];
      int                     errors;

      function new();
         foreach (path_dist[i]) begin
            path_dist[i] = D_NONE;
            settled[i] = 1'b0;
         end
         source_reg = '0;
         count_reg = VCNT_BITS'(MAX_VERTICES);
         readout_busy = 1'b0;
         next_vertex = 0;
         readout_len = 0;
         errors = 0;
      endfunction

      function void report(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endfunction

      function int unsigned active_count(logic [VCNT_BITS-1:0] value);
         if (value == 0) return 1;
         if (value > MAX_VERTICES) return MAX_VERTICES;
         return int'(value);
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [VCNT_BITS-1:0] value);
         if (index == CSR_SOURCE) begin
            source_reg = value[VIDX_BITS-1:0];
         end else begin
            count_reg = value;
         end
      endfunction

      function void search_distances(int unsigned n);
         logic [SUM_BITS-1:0]  sum;
         logic [DIST_BITS-1:0] low;
         int unsigned          u;
         bit                   found;
         for (int unsigned i = 0; i < n; i++) begin
            settled[i] = 1'b0;
            path_dist[i] = (edge_cost[source_reg][i] == W_NONE) ? D_NONE
                           : DIST_BITS'(edge_cost[source_reg][i]);
         end
         // a source outside the vertex count only supplies its row
         if (source_reg < n) begin
            path_dist[source_reg] = '0;
            settled[source_reg] = 1'b1;
         end
         for (int unsigned r = 1; r < n; r++) begin
            found = 1'b0;
            low = D_NONE;
            u = 0;
            for (int unsigned i = 0; i < n; i++) begin
               if (!settled[i] && path_dist[i] < low) begin
                  low = path_dist[i];
                  u = i;
                  found = 1'b1;
               end
            end
            if (!found) break;
            settled[u] = 1'b1;
            for (int unsigned i = 0; i < n; i++) begin
               if (!settled[i] && edge_cost[u][i] != W_NONE) begin
                  sum = SUM_BITS'(path_dist[u]) + SUM_BITS'(edge_cost[u][i]);
                  if (sum > SUM_BITS'(D_SAT)) sum = SUM_BITS'(D_SAT);
                  if (path_dist[i] > sum[DIST_BITS-1:0]) path_dist[i] = sum[DIST_BITS-1:0];
               end
            end
         end
      endfunction

      function void note_item(logic op, logic [VIDX_BITS-1:0] from_v,
                              logic [VIDX_BITS-1:0] to_v, logic [WEIGHT_BITS-1:0] weight);
         vertex_distance_type item;
         if (op == OP_LOAD) begin
            edge_cost[from_v][to_v] = weight;
            return;
         end
         if (!readout_busy) begin
            readout_len = active_count(count_reg);
            search_distances(readout_len);
            next_vertex = 0;
            readout_busy = 1'b1;
         end
         item.vertex = VIDX_BITS'(next_vertex);
         item.distance = path_dist[next_vertex];
         item.reachable = (path_dist[next_vertex] != D_NONE);
         item.last = (next_vertex + 1 >= readout_len);
         if (item.last) begin
            readout_busy = 1'b0;
            next_vertex = 0;
         end else begin
            next_vertex++;
         end
         expected_distances.push_back(item);
      endfunction

      function void check_distance(logic [VIDX_BITS-1:0] vertex, logic [DIST_BITS-1:0] distance,
                                   logic reachable, logic last);
         vertex_distance_type want;
         if (expected_distances.size() == 0) begin
            report($sformatf("result for vertex %0d with nothing outstanding", vertex));
            return;
         end
         want = expected_distances.pop_front();
         if (vertex !== want.vertex)
            report($sformatf("vertex %0h, expected %0h", vertex, want.vertex));
         if (distance !== want.distance)
            report($sformatf("vertex %0d distance %0h, expected %0h",
                             want.vertex, distance, want.distance));
         if (reachable !== want.reachable)
            report($sformatf("vertex %0d reachable %b, expected %b",
                             want.vertex, reachable, want.reachable));
         if (last !== want.last)
            report($sformatf("vertex %0d last %b, expected %b", want.vertex, last, want.last));
      endfunction
   endclass

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   // from_vertex, to_vertex, weight
   logic [REQ_TDATA_BITS-1:0]     req_tdata = '0;
   // op
   logic                          req_tuser = OP_LOAD;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // vertex, distance, reachable, zero fill
   logic [RSP_TDATA_BITS-1:0]     rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = CSR_SOURCE;
   logic [VCNT_BITS-1:0]          csr_wdata = '0;

   distance_tracker_type tracker;
   bit              calm = 1'b0;
   logic            hold_rx = 1'b0;
   bit              hold_done = 1'b0;
   int              quiet_cycles = 0;
   int unsigned     sent_items = 0;

   single_source_shortest_path DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // transfers on both channels go to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            tracker.check_distance(rsp_tdata[VIDX_BITS-1:0], rsp_tdata[VIDX_BITS +: DIST_BITS],
                                   rsp_tdata[VIDX_BITS+DIST_BITS], rsp_tlast);
         if (req_tvalid && req_tready)
            tracker.note_item(req_tuser, req_tdata[0 +: VIDX_BITS],
                              req_tdata[VIDX_BITS +: VIDX_BITS],
                              req_tdata[2*VIDX_BITS +: WEIGHT_BITS]);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result receiver: random backpressure, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rx && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= 24);
         end
      end
   end

   function automatic logic [WEIGHT_BITS-1:0] pick_weight();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return W_NONE;
      if (roll < 35) return '0;
      // small weights give plenty of ties
      if (roll < 90) return WEIGHT_BITS'($urandom_range(1, 12));
      return WEIGHT_BITS'($urandom_range(13, 16'hFFFE));
   endfunction

   // tvalid stays high across back-to-back transfers
   task automatic send_item(input logic op, input logic [VIDX_BITS-1:0] from_v,
                            input logic [VIDX_BITS-1:0] to_v,
                            input logic [WEIGHT_BITS-1:0] weight);
      if (!calm) begin
         while ($urandom_range(0, 99) < 24) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_TDATA_BITS'({weight, to_v, from_v});
      do @(posedge clock); while (req_tready !== 1'b1);
      sent_items++;
   endtask

   task automatic send_random_load();
      send_item(OP_LOAD, VIDX_BITS'($urandom_range(0, 15)), VIDX_BITS'($urandom_range(0, 15)),
                pick_weight());
   endtask

   task automatic send_run();
      send_item(OP_RUN, VIDX_BITS'($urandom_range(0, 15)), VIDX_BITS'($urandom_range(0, 15)),
                WEIGHT_BITS'($urandom_range(0, 16'hFFFF)));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_distances.size() != 0) @(posedge clock);
      // a trailing load may still be in work
      repeat (8) @(posedge clock);
   endtask

   task automatic write_regs(input logic [VCNT_BITS-1:0] source_word,
                             input logic [VCNT_BITS-1:0] count_word);
      csr_we <= 1'b1;
      csr_index <= CSR_SOURCE;
      csr_wdata <= source_word;
      @(posedge clock);
      csr_index <= CSR_COUNT;
      csr_wdata <= count_word;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_register(CSR_SOURCE, source_word);
      tracker.set_register(CSR_COUNT, count_word);
   endtask

   task automatic run_phase(input int unsigned n_eff);
      int unsigned len;
      repeat ($urandom_range(1, 3)) begin
         repeat ($urandom_range(0, 5)) send_random_load();
         // mostly complete readouts, some cut short
         len = ($urandom_range(0, 99) < 80) ? n_eff : $urandom_range(1, n_eff);
         repeat (len) begin
            if ($urandom_range(0, 99) < 15) send_random_load();
            send_run();
         end
      end
   endtask

   initial begin
      int unsigned            phase;
      logic [VCNT_BITS-1:0]   count_word;
      logic [VCNT_BITS-1:0]   source_word;
      tracker = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every matrix entry gets a value before any search reads it
      for (int r = 0; r < MAX_VERTICES; r++)
         for (int c = 0; c < MAX_VERTICES; c++)
            send_item(OP_LOAD, VIDX_BITS'(r), VIDX_BITS'(c), pick_weight());
      wait_idle();

      // zero weight, no edge, largest real weight, a load during the readout
      write_regs(VCNT_BITS'(0), VCNT_BITS'(MAX_VERTICES));
      send_item(OP_LOAD, 4'd0, 4'd1, '0);
      send_item(OP_LOAD, 4'd0, 4'd2, W_NONE);
      send_run();
      send_item(OP_LOAD, 4'd1, 4'd2, 16'hFFFE);
      repeat (MAX_VERTICES - 1) send_run();
      wait_idle();
      // count of zero acts as one
      write_regs(VCNT_BITS'(15), VCNT_BITS'(0));
      send_run();
      wait_idle();
      // source outside the vertices in use
      write_regs(VCNT_BITS'(9), VCNT_BITS'(4));
      repeat (4) send_run();

      phase = 0;
      while (sent_items < TARGET_ITEMS) begin
         wait_idle();
         calm = (phase >= 7 && phase < 12);
         case (phase)
            0: count_word = VCNT_BITS'(1);
            1, 2: count_word = VCNT_BITS'(MAX_VERTICES);
            3: count_word = VCNT_BITS'(0);
            4: count_word = VCNT_BITS'(31);
            5: count_word = VCNT_BITS'(17);
            6: count_word = VCNT_BITS'(2);
            default: begin
               if ($urandom_range(0, 99) < 65)
                  count_word = VCNT_BITS'($urandom_range(2, 6));
               else if ($urandom_range(0, 99) < 60)
                  count_word = VCNT_BITS'($urandom_range(7, 16));
               else
                  count_word = VCNT_BITS'($urandom_range(0, 31));
            end
         endcase
         source_word = VCNT_BITS'($urandom_range(0, 31));
         write_regs(source_word, count_word);
         // receiver stalls while the sender keeps offering
         if (phase == 2) hold_rx <= 1'b1;
         run_phase(tracker.active_count(count_word));
         phase++;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
